>>> sv/sync_frame_parser_crc16_macros.svh
// Assertion macros shared by the deframer modules.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef SYNC_FRAME_PARSER_CRC16_MACROS_SVH
`define SYNC_FRAME_PARSER_CRC16_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SFP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/sfp_pkg.sv
package sfp_pkg;

    // Default width of the saturating frame counters.
    localparam int COUNT_BITS_DEF = 32;

    // Depth of the event queue between parser and output stage.
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Configuration port widths.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_SYNC_FIRST    = 3'd0,
        REG_SYNC_SECOND   = 3'd1,
        REG_END_BYTE      = 3'd2,
        REG_PAYLOAD_LIMIT = 3'd3,
        REG_CRC_SEED      = 3'd4
    } cfg_reg_t;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CMD     = 4'd2,
        PH_LEN_LO  = 4'd3,
        PH_LEN_HI  = 4'd4,
        PH_PAYLOAD = 4'd5,
        PH_CRC_LO  = 4'd6,
        PH_CRC_HI  = 4'd7,
        PH_END     = 4'd8
    } phase_t;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ACCEPT  = 2'd1,
        KIND_CRC_ERR = 2'd2,
        KIND_END_ERR = 2'd3
    } kind_t;

    // Configuration register set.
    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  end_byte;
        logic [15:0] payload_limit;
        logic [15:0] crc_seed;
    } cfg_t;

    // One event handed from the parser to the output stage.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  command;
        logic [15:0] frame_length;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
    } event_t;

    // CRC-16 update by one byte, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> sv/sync_frame_parser_crc16.sv
// Channel   Direction  Handshake              Content
// in        input      in_valid / in_ready    rx_byte
// out       output     out_valid / out_ready  kind, command, frame_length, data_byte,
//                                             byte_index, crc_error_count, good_frame_count
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is accepted per cycle while the queue has room; a result, if any, is written into
// the event queue and then loaded into the output register before it is presented.
// The parser and CRC update are combinational between the parser state registers.
// A four-entry event queue and the output register let input continue while output stalls;
// input stalls only once the queue is full. Configuration writes are always taken.
// Reset is asynchronous, active low, and needs no clearing pass.
module sync_frame_parser_crc16
#(
    parameter int COUNT_BITS = sfp_pkg::COUNT_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         kind,
    output logic [7:0]                         command,
    output logic [15:0]                        frame_length,
    output logic [7:0]                         data_byte,
    output logic [15:0]                        byte_index,
    output logic [31:0]                        crc_error_count,
    output logic [31:0]                        good_frame_count,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sfp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sfp_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    sfp_pkg::cfg_t   cfg_reg;
    logic            q_ready;
    logic            q_valid;
    logic            push;
    logic            pop;
    sfp_pkg::event_t push_event;
    sfp_pkg::event_t pop_event;

    assign cfg_ready = 1'b1;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_first    <= 8'hAA;
            cfg_reg.sync_second   <= 8'h55;
            cfg_reg.end_byte      <= 8'h0D;
            cfg_reg.payload_limit <= 16'd1024;
            cfg_reg.crc_seed      <= 16'hFFFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (sfp_pkg::cfg_reg_t'(cfg_index))
                sfp_pkg::REG_SYNC_FIRST:    cfg_reg.sync_first    <= cfg_data[7:0];
                sfp_pkg::REG_SYNC_SECOND:   cfg_reg.sync_second   <= cfg_data[7:0];
                sfp_pkg::REG_END_BYTE:      cfg_reg.end_byte      <= cfg_data[7:0];
                sfp_pkg::REG_PAYLOAD_LIMIT: cfg_reg.payload_limit <= cfg_data;
                sfp_pkg::REG_CRC_SEED:      cfg_reg.crc_seed      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Parser: classifies bytes and raises events.
    sfp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .q_ready    (q_ready),
        .push       (push),
        .push_event (push_event)
    );

    // Event queue between parser and output stage.
    sfp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_event (push_event),
        .q_ready    (q_ready),
        .pop        (pop),
        .q_valid    (q_valid),
        .pop_event  (pop_event)
    );

    // Output stage with frame counters.
    sfp_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .pop_event        (pop_event),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .command          (command),
        .frame_length     (frame_length),
        .data_byte        (data_byte),
        .byte_index       (byte_index),
        .crc_error_count  (crc_error_count),
        .good_frame_count (good_frame_count)
    );

endmodule

>>> sv/sfp_front.sv
`include "sync_frame_parser_crc16_macros.svh"

module sfp_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  sfp_pkg::cfg_t     cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    input  logic              q_ready,
    output logic              push,
    output sfp_pkg::event_t   push_event
);

    sfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      cmd_reg, cmd_next;
    logic [15:0]     len_reg, len_next;
    logic [15:0]     count_reg, count_next;
    logic [7:0]      rx_lo_reg, rx_lo_next;
    logic [15:0]     crc_reg, crc_next;

    logic            accept;
    logic            emit;
    logic [15:0]     crc_fed;
    logic [15:0]     len_full;
    logic [15:0]     count_inc;
    logic            in_payload;
    logic            result_phase;

    // A byte is taken whenever the queue has room for a possible event.
    assign in_ready  = q_ready;
    assign accept    = in_valid && in_ready;
    assign crc_fed   = sfp_pkg::crc16_byte(crc_reg, rx_byte);
    assign len_full  = {rx_byte, len_reg[7:0]};
    assign count_inc = count_reg + 16'd1;
    assign push      = accept && emit;

    // Phases in which an event may be raised.
    assign in_payload   = (phase_reg == sfp_pkg::PH_PAYLOAD);
    assign result_phase = in_payload || (phase_reg == sfp_pkg::PH_CRC_HI)
                          || (phase_reg == sfp_pkg::PH_END);

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfp_pkg::PH_SYNC1;
            cmd_reg   <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            rx_lo_reg <= '0;
            crc_reg   <= 16'hFFFF;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            rx_lo_reg <= rx_lo_next;
            crc_reg   <= crc_next;
        end
    end

    // Phase decoding, CRC update and event formation.
    always_comb
    begin
        phase_next              = phase_reg;
        cmd_next                = cmd_reg;
        len_next                = len_reg;
        count_next              = count_reg;
        rx_lo_next              = rx_lo_reg;
        crc_next                = crc_reg;
        emit                    = 1'b0;
        push_event              = '0;
        push_event.kind         = sfp_pkg::KIND_PAYLOAD;
        push_event.command      = cmd_reg;
        push_event.frame_length = len_reg;

        unique case (phase_reg)
            sfp_pkg::PH_SYNC2:
            begin
                if (rx_byte == cfg.sync_second)
                begin
                    phase_next = sfp_pkg::PH_CMD;
                    cmd_next   = '0;
                    len_next   = '0;
                    count_next = '0;
                    rx_lo_next = '0;
                    crc_next   = cfg.crc_seed;
                end
                else if (rx_byte != cfg.sync_first)
                begin
                    phase_next = sfp_pkg::PH_SYNC1;
                end
            end
            sfp_pkg::PH_CMD:
            begin
                cmd_next   = rx_byte;
                crc_next   = crc_fed;
                phase_next = sfp_pkg::PH_LEN_LO;
            end
            sfp_pkg::PH_LEN_LO:
            begin
                len_next   = {8'h00, rx_byte};
                crc_next   = crc_fed;
                phase_next = sfp_pkg::PH_LEN_HI;
            end
            sfp_pkg::PH_LEN_HI:
            begin
                len_next = len_full;
                crc_next = crc_fed;
                if (len_full > cfg.payload_limit)
                begin
                    phase_next = sfp_pkg::PH_SYNC1;
                end
                else if (len_full == 16'd0)
                begin
                    phase_next = sfp_pkg::PH_CRC_LO;
                end
                else
                begin
                    count_next = '0;
                    phase_next = sfp_pkg::PH_PAYLOAD;
                end
            end
            sfp_pkg::PH_PAYLOAD:
            begin
                crc_next              = crc_fed;
                emit                  = 1'b1;
                push_event.data_byte  = rx_byte;
                push_event.byte_index = count_reg;
                count_next            = count_inc;
                if (count_inc >= len_reg)
                begin
                    phase_next = sfp_pkg::PH_CRC_LO;
                end
            end
            sfp_pkg::PH_CRC_LO:
            begin
                rx_lo_next = rx_byte;
                phase_next = sfp_pkg::PH_CRC_HI;
            end
            sfp_pkg::PH_CRC_HI:
            begin
                if ({rx_byte, rx_lo_reg} == crc_reg)
                begin
                    phase_next = sfp_pkg::PH_END;
                end
                else
                begin
                    emit            = 1'b1;
                    push_event.kind = sfp_pkg::KIND_CRC_ERR;
                    phase_next      = sfp_pkg::PH_SYNC1;
                end
            end
            sfp_pkg::PH_END:
            begin
                emit            = 1'b1;
                push_event.kind = (rx_byte == cfg.end_byte) ? sfp_pkg::KIND_ACCEPT
                                                            : sfp_pkg::KIND_END_ERR;
                phase_next      = sfp_pkg::PH_SYNC1;
            end
            default:
            begin
                // Waiting for the first sync byte, also for unused codes.
                phase_next = (rx_byte == cfg.sync_first) ? sfp_pkg::PH_SYNC2
                                                         : sfp_pkg::PH_SYNC1;
            end
        endcase
    end

    // Events only come from the payload, CRC check and end marker phases.
    `SFP_ASSERT_SAME(a_emit_phase, emit, result_phase, "event raised outside a result phase")
    // Within the payload the running index stays below the announced length.
    `SFP_ASSERT_SAME(a_payload_idx, in_payload, count_reg < len_reg, "payload index reached length")

endmodule

>>> sv/sfp_queue.sv
`include "sync_frame_parser_crc16_macros.svh"

module sfp_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sfp_pkg::event_t push_event,
    output logic            q_ready,
    input  logic            pop,
    output logic            q_valid,
    output sfp_pkg::event_t pop_event
);

    localparam logic [sfp_pkg::QUEUE_CNT_BITS-1:0] FULL_COUNT =
        sfp_pkg::QUEUE_CNT_BITS'(sfp_pkg::QUEUE_DEPTH);

    sfp_pkg::event_t                     mem [sfp_pkg::QUEUE_DEPTH];
    logic [sfp_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [sfp_pkg::QUEUE_CNT_BITS-1:0]  count_reg;
    logic                                do_pop;

    assign q_ready   = (count_reg != FULL_COUNT);
    assign q_valid   = (count_reg != '0);
    assign pop_event = mem[rd_ptr_reg];
    assign do_pop    = pop && q_valid;

    // Storage for queued events.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_event;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + sfp_pkg::QUEUE_PTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + sfp_pkg::QUEUE_PTR_BITS'(1);
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + sfp_pkg::QUEUE_CNT_BITS'(1);
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - sfp_pkg::QUEUE_CNT_BITS'(1);
            end
        end
    end

    // The fill count never passes the depth.
    `SFP_ASSERT_SAME(a_q_bound, 1'b1, count_reg <= FULL_COUNT, "queue count beyond depth")
    // A push into a full queue would overwrite the oldest event.
    `SFP_ASSERT_SAME(a_q_no_over, push, q_ready, "push into full queue")

endmodule

>>> sv/sfp_back.sv
`include "sync_frame_parser_crc16_macros.svh"

module sfp_back
#(
    parameter int COUNT_BITS = sfp_pkg::COUNT_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  sfp_pkg::event_t pop_event,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [1:0]      kind,
    output logic [7:0]      command,
    output logic [15:0]     frame_length,
    output logic [7:0]      data_byte,
    output logic [15:0]     byte_index,
    output logic [31:0]     crc_error_count,
    output logic [31:0]     good_frame_count
);

    logic                  out_valid_reg;
    sfp_pkg::event_t       res_reg;
    logic [COUNT_BITS-1:0] bad_reg, bad_next;
    logic [COUNT_BITS-1:0] good_reg, good_next;

    // Load the output register when it is empty or being drained.
    assign pop = q_valid && (!out_valid_reg || out_ready);

    // Saturating counters advance with the event that is loaded.
    always_comb
    begin
        bad_next  = bad_reg;
        good_next = good_reg;
        if (pop_event.kind == sfp_pkg::KIND_CRC_ERR && bad_reg != {COUNT_BITS{1'b1}})
        begin
            bad_next = bad_reg + COUNT_BITS'(1);
        end
        if (pop_event.kind == sfp_pkg::KIND_ACCEPT && good_reg != {COUNT_BITS{1'b1}})
        begin
            good_next = good_reg + COUNT_BITS'(1);
        end
    end

    // Output register and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            bad_reg       <= '0;
            good_reg      <= '0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
            bad_reg       <= bad_next;
            good_reg      <= good_next;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= pop_event;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = res_reg.kind;
    assign command          = res_reg.command;
    assign frame_length     = res_reg.frame_length;
    assign data_byte        = res_reg.data_byte;
    assign byte_index       = res_reg.byte_index;
    assign crc_error_count  = 32'(bad_reg);
    assign good_frame_count = 32'(good_reg);

    // Counters never go backwards.
    `SFP_ASSERT_NEXT(a_bad_mono, 1'b1, bad_reg >= $past(bad_reg), "CRC error count decreased")
    `SFP_ASSERT_NEXT(a_good_mono, 1'b1, good_reg >= $past(good_reg), "good frame count decreased")

endmodule

>>> tb/tb_sync_frame_parser_crc16.sv
`timescale 1ns / 1ps

module tb_sync_frame_parser_crc16;

    localparam int CLK_HALF       = 5;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    // One verdict or payload byte as the output channel presents it.
    typedef struct packed {
        sfp_pkg::kind_t kind;
        logic [7:0]     command;
        logic [15:0]    frame_length;
        logic [7:0]     data_byte;
        logic [15:0]    byte_index;
        logic [31:0]    crc_errors;
        logic [31:0]    good_frames;
    } frame_event_t;

    typedef struct packed {
        logic [sfp_pkg::CFG_INDEX_BITS-1:0] index;
        logic [sfp_pkg::CFG_DATA_BITS-1:0]  data;
    } reg_write_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic [7:0]                         rx_byte = 8'h00;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic [1:0]                         kind;
    logic [7:0]                         command;
    logic [15:0]                        frame_length;
    logic [7:0]                         data_byte;
    logic [15:0]                        byte_index;
    logic [31:0]                        crc_error_count;
    logic [31:0]                        good_frame_count;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [sfp_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [sfp_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;

    // Stimulus queues and expected results.
    logic [7:0]   outbound_bytes[$];
    reg_write_t   reg_writes[$];
    frame_event_t due_events[$];

    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int bytes_queued = 0;
    int bytes_taken = 0;
    int writes_done = 0;
    int results_checked = 0;
    int mismatch_total = 0;
    int quiet_cycles = 0;
    int settings_run = 0;
    int payload_seen = 0;
    int accepted_seen = 0;
    int crc_err_seen = 0;
    int end_err_seen = 0;

    // Shadow of the deframer: register set and parser state.
    sfp_pkg::cfg_t   shadow_cfg = '{8'hAA, 8'h55, 8'h0D, 16'd1024, 16'hFFFF};
    sfp_pkg::phase_t rx_phase = sfp_pkg::PH_SYNC1;
    logic [7:0]      rx_cmd = '0;
    logic [15:0]     rx_len = '0;
    logic [15:0]     rx_count = '0;
    logic [15:0]     rx_got_crc = '0;
    logic [15:0]     rx_crc = 16'hFFFF;
    logic [31:0]     rx_bad = '0;
    logic [31:0]     rx_good = '0;

    sync_frame_parser_crc16 i_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .command          (command),
        .frame_length     (frame_length),
        .data_byte        (data_byte),
        .byte_index       (byte_index),
        .crc_error_count  (crc_error_count),
        .good_frame_count (good_frame_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // CRC-16 over one byte, feeding the data bits in from the top.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb = r[15] ^ b[i];
            r  = {r[14:0], 1'b0} ^ (fb ? sfp_pkg::CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    // Advances the shadow parser by one byte and records any result it raises.
    task automatic deframe_byte(input logic [7:0] b);
        frame_event_t ev;
        bit           emit;
        ev   = '0;
        emit = 1'b0;
        case (rx_phase)
            sfp_pkg::PH_SYNC2:
            begin
                // The second sync test comes first; a repeated first sync keeps waiting.
                if (b == shadow_cfg.sync_second)
                begin
                    rx_phase   = sfp_pkg::PH_CMD;
                    rx_cmd     = '0;
                    rx_len     = '0;
                    rx_count   = '0;
                    rx_got_crc = '0;
                    rx_crc     = shadow_cfg.crc_seed;
                end
                else if (b != shadow_cfg.sync_first)
                    rx_phase = sfp_pkg::PH_SYNC1;
            end
            sfp_pkg::PH_CMD:
            begin
                rx_cmd   = b;
                rx_crc   = crc_step(rx_crc, b);
                rx_phase = sfp_pkg::PH_LEN_LO;
            end
            sfp_pkg::PH_LEN_LO:
            begin
                rx_len   = {8'h00, b};
                rx_crc   = crc_step(rx_crc, b);
                rx_phase = sfp_pkg::PH_LEN_HI;
            end
            sfp_pkg::PH_LEN_HI:
            begin
                rx_len[15:8] = b;
                rx_crc       = crc_step(rx_crc, b);
                if (rx_len > shadow_cfg.payload_limit)
                    rx_phase = sfp_pkg::PH_SYNC1;
                else if (rx_len == 16'd0)
                    rx_phase = sfp_pkg::PH_CRC_LO;
                else
                begin
                    rx_count = '0;
                    rx_phase = sfp_pkg::PH_PAYLOAD;
                end
            end
            sfp_pkg::PH_PAYLOAD:
            begin
                rx_crc        = crc_step(rx_crc, b);
                emit          = 1'b1;
                ev.kind       = sfp_pkg::KIND_PAYLOAD;
                ev.data_byte  = b;
                ev.byte_index = rx_count;
                rx_count      = rx_count + 16'd1;
                if (rx_count >= rx_len)
                    rx_phase = sfp_pkg::PH_CRC_LO;
            end
            sfp_pkg::PH_CRC_LO:
            begin
                rx_got_crc = {8'h00, b};
                rx_phase   = sfp_pkg::PH_CRC_HI;
            end
            sfp_pkg::PH_CRC_HI:
            begin
                rx_got_crc[15:8] = b;
                if (rx_got_crc == rx_crc)
                    rx_phase = sfp_pkg::PH_END;
                else
                begin
                    if (rx_bad != '1)
                        rx_bad = rx_bad + 32'd1;
                    emit     = 1'b1;
                    ev.kind  = sfp_pkg::KIND_CRC_ERR;
                    rx_phase = sfp_pkg::PH_SYNC1;
                end
            end
            sfp_pkg::PH_END:
            begin
                emit = 1'b1;
                if (b == shadow_cfg.end_byte)
                begin
                    if (rx_good != '1)
                        rx_good = rx_good + 32'd1;
                    ev.kind = sfp_pkg::KIND_ACCEPT;
                end
                else
                    ev.kind = sfp_pkg::KIND_END_ERR;
                rx_phase = sfp_pkg::PH_SYNC1;
            end
            default:
                rx_phase = (b == shadow_cfg.sync_first) ? sfp_pkg::PH_SYNC2
                                                        : sfp_pkg::PH_SYNC1;
        endcase
        if (emit)
        begin
            ev.command      = rx_cmd;
            ev.frame_length = rx_len;
            ev.crc_errors   = rx_bad;
            ev.good_frames  = rx_good;
            due_events.insert(due_events.size(), ev);
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        outbound_bytes.insert(outbound_bytes.size(), b);
        bytes_queued++;
    endtask

    // Builds a frame under the current register set. A negative fill gives random
    // payload bytes; a non-negative keep truncates the frame to that many bytes.
    task automatic queue_frame(input logic [7:0] cmd, input logic [15:0] len, input int fill,
                               input bit crc_fault, input bit end_fault, input int keep);
        logic [7:0]  frame_bytes[$];
        logic [15:0] crc;
        logic [7:0]  pb;
        crc = shadow_cfg.crc_seed;
        frame_bytes.insert(frame_bytes.size(), shadow_cfg.sync_first);
        frame_bytes.insert(frame_bytes.size(), shadow_cfg.sync_second);
        frame_bytes.insert(frame_bytes.size(), cmd);
        frame_bytes.insert(frame_bytes.size(), len[7:0]);
        frame_bytes.insert(frame_bytes.size(), len[15:8]);
        crc = crc_step(crc, cmd);
        crc = crc_step(crc, len[7:0]);
        crc = crc_step(crc, len[15:8]);
        for (int i = 0; i < len; i++)
        begin
            pb = (fill < 0) ? 8'($urandom) : 8'(fill);
            frame_bytes.insert(frame_bytes.size(), pb);
            crc = crc_step(crc, pb);
        end
        if (crc_fault)
            crc = crc ^ 16'($urandom_range(1, 65535));
        frame_bytes.insert(frame_bytes.size(), crc[7:0]);
        frame_bytes.insert(frame_bytes.size(), crc[15:8]);
        if (end_fault)
            frame_bytes.insert(frame_bytes.size(),
                               shadow_cfg.end_byte ^ 8'($urandom_range(1, 255)));
        else
            frame_bytes.insert(frame_bytes.size(), shadow_cfg.end_byte);
        foreach (frame_bytes[i])
        begin
            if (keep < 0 || i < keep)
                push_byte(frame_bytes[i]);
        end
    endtask

    // A header announcing more payload than the limit allows.
    task automatic queue_oversize(input logic [7:0] cmd, input logic [15:0] len);
        push_byte(shadow_cfg.sync_first);
        push_byte(shadow_cfg.sync_second);
        push_byte(cmd);
        push_byte(len[7:0]);
        push_byte(len[15:8]);
    endtask

    // Mostly well-formed frames with random content; the rest is noise,
    // oversize headers and frames cut short after their header.
    task automatic queue_random_traffic(input int budget);
        int          start;
        int          pick;
        logic [15:0] len;
        start = bytes_queued;
        while (bytes_queued - start < budget)
        begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                len = 16'($urandom_range(9, 40));
            else
                len = 16'($urandom_range(0, 8));
            if (len > shadow_cfg.payload_limit)
                len = shadow_cfg.payload_limit;
            if (pick < 65 || (pick < 75 && shadow_cfg.payload_limit == 16'hFFFF))
            begin
                if ($urandom_range(0, 9) == 0)
                    push_byte(shadow_cfg.sync_first);
                queue_frame(8'($urandom), len, -1, $urandom_range(0, 7) == 0,
                            $urandom_range(0, 7) == 0, -1);
            end
            else if (pick < 75)
                queue_oversize(8'($urandom),
                               16'($urandom_range(shadow_cfg.payload_limit + 1, 65535)));
            else if (pick < 88)
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
            else
                queue_frame(8'($urandom), len, -1, 1'b0, 1'b0, $urandom_range(5, len + 7));
        end
    endtask

    task automatic write_reg(input logic [sfp_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [sfp_pkg::CFG_DATA_BITS-1:0] val);
        reg_write_t wr;
        int         target;
        wr.index = idx;
        wr.data  = val;
        target   = writes_done + 1;
        reg_writes.insert(reg_writes.size(), wr);
        while (writes_done < target)
            @(posedge clk);
    endtask

    // Holds off until every queued byte is taken and every expected result has
    // arrived, then gives the pipeline time to finish bytes that raise no result.
    task automatic settle();
        while (bytes_taken != bytes_queued || due_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Driver: input byte and register write transactions.
    always @(posedge clk)
    begin : driver
        reg_write_t wr;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                deframe_byte(rx_byte);
                bytes_taken++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (sfp_pkg::cfg_reg_t'(cfg_index))
                    sfp_pkg::REG_SYNC_FIRST:    shadow_cfg.sync_first    = cfg_data[7:0];
                    sfp_pkg::REG_SYNC_SECOND:   shadow_cfg.sync_second   = cfg_data[7:0];
                    sfp_pkg::REG_END_BYTE:      shadow_cfg.end_byte      = cfg_data[7:0];
                    sfp_pkg::REG_PAYLOAD_LIMIT: shadow_cfg.payload_limit = cfg_data;
                    sfp_pkg::REG_CRC_SEED:      shadow_cfg.crc_seed      = cfg_data;
                    default:                    ;
                endcase
                writes_done++;
            end
            if (!in_valid || in_ready)
            begin
                if (outbound_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    rx_byte  <= outbound_bytes.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_writes.size() != 0)
                begin
                    wr = reg_writes.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= wr.index;
                    cfg_data  <= wr.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each output transaction with the oldest expectation.
    always @(posedge clk)
    begin : monitor
        frame_event_t seen;
        frame_event_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen.kind         = sfp_pkg::kind_t'(kind);
                seen.command      = command;
                seen.frame_length = frame_length;
                seen.data_byte    = data_byte;
                seen.byte_index   = byte_index;
                seen.crc_errors   = crc_error_count;
                seen.good_frames  = good_frame_count;
                case (seen.kind)
                    sfp_pkg::KIND_PAYLOAD: payload_seen++;
                    sfp_pkg::KIND_ACCEPT:  accepted_seen++;
                    sfp_pkg::KIND_CRC_ERR: crc_err_seen++;
                    default:               end_err_seen++;
                endcase
                if (due_events.size() == 0)
                begin
                    if (mismatch_total < REPORT_LIMIT)
                        $display("Unexpected result at %0t: kind %0d cmd %h len %h",
                                 $realtime, seen.kind, seen.command, seen.frame_length);
                    mismatch_total++;
                end
                else
                begin
                    want = due_events.pop_front();
                    results_checked++;
                    if (seen !== want)
                    begin
                        if (mismatch_total < REPORT_LIMIT)
                        begin
                            $display("Result %0d at %0t differs", results_checked, $realtime);
                            $display("  expected kind %0d cmd %h len %h data %h idx %h",
                                     want.kind, want.command, want.frame_length,
                                     want.data_byte, want.byte_index);
                            $display("           crc %0d good %0d",
                                     want.crc_errors, want.good_frames);
                            $display("  actual   kind %0d cmd %h len %h data %h idx %h",
                                     seen.kind, seen.command, seen.frame_length,
                                     seen.data_byte, seen.byte_index);
                            $display("           crc %0d good %0d",
                                     seen.crc_errors, seen.good_frames);
                        end
                        mismatch_total++;
                    end
                end
            end
            out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Watchdog: ends the run when no transaction completes for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout after %0d idle cycles", quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register set; sender idles less than the receiver.
        sender_idle_pct   = 32;
        receiver_idle_pct = 47;
        settings_run++;

        // Repeated first sync, then a good zero-length frame with the top command.
        push_byte(shadow_cfg.sync_first);
        queue_frame(8'hFF, 16'd0, -1, 1'b0, 1'b0, -1);
        // A stray byte after the first sync restarts the search.
        push_byte(shadow_cfg.sync_first);
        push_byte(8'h00);
        // One all-ones payload byte followed by a bad CRC.
        queue_frame(8'h00, 16'd1, 8'hFF, 1'b1, 1'b0, -1);
        // Largest possible length, well over the limit: silent restart.
        queue_oversize(8'h5A, 16'hFFFF);
        // Good CRC but the wrong end marker.
        queue_frame(8'($urandom), 16'd0, -1, 1'b0, 1'b1, -1);

        // The sender waits here for every outstanding result.
        settle();
        queue_random_traffic(230);
        settle();

        // Low extremes; the receiver now idles less than the sender.
        sender_idle_pct   = 47;
        receiver_idle_pct = 32;
        settings_run++;
        write_reg(sfp_pkg::REG_SYNC_FIRST, {8'($urandom), 8'h00});
        write_reg(sfp_pkg::REG_SYNC_SECOND, {8'($urandom), 8'hFF});
        write_reg(sfp_pkg::REG_END_BYTE, {8'($urandom), 8'h00});
        write_reg(sfp_pkg::REG_PAYLOAD_LIMIT, 16'h0000);
        write_reg(sfp_pkg::REG_CRC_SEED, 16'h0000);
        queue_random_traffic(230);
        settle();

        // High extremes with no idling on either side.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        settings_run++;
        write_reg(sfp_pkg::REG_SYNC_FIRST, 16'hFFFF);
        write_reg(sfp_pkg::REG_SYNC_SECOND, {8'($urandom), 8'h00});
        write_reg(sfp_pkg::REG_END_BYTE, 16'h00FF);
        write_reg(sfp_pkg::REG_PAYLOAD_LIMIT, 16'hFFFF);
        write_reg(sfp_pkg::REG_CRC_SEED, 16'hFFFF);
        queue_random_traffic(230);
        settle();

        // Random register set with a small limit; a write to an unused index is ignored.
        settings_run++;
        write_reg(sfp_pkg::REG_SYNC_FIRST, 16'($urandom));
        write_reg(sfp_pkg::REG_SYNC_SECOND, 16'($urandom));
        write_reg(sfp_pkg::REG_END_BYTE, 16'($urandom));
        write_reg(sfp_pkg::REG_PAYLOAD_LIMIT, 16'($urandom_range(3, 10)));
        write_reg(sfp_pkg::REG_CRC_SEED, 16'($urandom));
        write_reg(sfp_pkg::CFG_INDEX_BITS'($urandom_range(sfp_pkg::REG_CRC_SEED + 1, 7)),
                  16'($urandom));
        queue_random_traffic(240);
        settle();

        mismatch_total += due_events.size();
        $display("Sent %0d bytes under %0d register settings and checked %0d results",
                 bytes_taken, settings_run, results_checked);
        $display("Seen %0d payload bytes, %0d accepted, %0d CRC errors, %0d bad end markers",
                 payload_seen, accepted_seen, crc_err_seen, end_err_seen);
        if (mismatch_total == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
